/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the voice allocator, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define ASSERT_NEXT(label, cond, cons, msg) \
  `ASSERT_CLK(label, (cond) |=> (cons), msg)

`endif

/* design/svalloc_pkg.sv */
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared types and constants for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package svalloc_pkg;

  localparam int VOICES_DEF     = 8;
  localparam int STAMP_BITS_DEF = 32;

  localparam int         COUNT_W   = 4;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  localparam logic REQ_NOTE_ON  = 1'b0;
  localparam logic REQ_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  note_number;
    logic [7:0]  idle_voices;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] granted_voice;
    logic [7:0] release_mask;
    logic       all_released;
  } rsp_t;

endpackage

`default_nettype wire

/* design/synth_voice_allocator.sv */
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Polyphonic voice allocator: idle-first, oldest-released voice stealing.
// ----------------------------------------------------------------------------
// Each request is handled alone: the block scans the voices one per cycle
// through a single stamp comparator. A note on stops at the first free voice
// with an idle envelope, and a note off scans every voice. The result is
// registered in S_COMMIT and copied to the response register in S_DONE. The
// next request is accepted in the cycle after the response is loaded, even
// while that response is still stalled at the output.
`default_nettype none

module synth_voice_allocator #(
  parameter int VOICES     = svalloc_pkg::VOICES_DEF,
  parameter int STAMP_BITS = svalloc_pkg::STAMP_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire svalloc_pkg::req_t  req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output svalloc_pkg::rsp_t       rsp
);

  localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MASK_W = (VOICES > 8) ? VOICES : 8;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t                         state;
  svalloc_pkg::req_t              cur;
  svalloc_pkg::rsp_t              res;
  svalloc_pkg::rsp_t              res_next;
  logic [IDX_W-1:0]               idx;
  logic [IDX_W-1:0]               pick;
  logic                           found;
  logic [STAMP_BITS-1:0]          best;
  logic [MASK_W-1:0]              mask_ext;
  logic [MASK_W-1:0]              idle_ext;
  logic [VOICES-1:0]              voice_busy;
  logic [6:0]                     voice_note [VOICES];
  logic [STAMP_BITS-1:0]          release_stamp [VOICES];
  logic [svalloc_pkg::COUNT_W-1:0] active_count;
  logic [STAMP_BITS-1:0]          cur_stamp;
  logic [STAMP_BITS-1:0]          stamp_now;
  logic                           commit_on;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    idle_ext      = '0;
    idle_ext[7:0] = cur.idle_voices;
  end

  assign cur_stamp = release_stamp[idx];
  assign stamp_now = STAMP_BITS'(cur.now_time);
  assign commit_on = (state == S_COMMIT) && (cur.req_type == svalloc_pkg::REQ_NOTE_ON);

  always_comb begin
    res_next = '0;
    if (cur.req_type == svalloc_pkg::REQ_NOTE_ON) begin
      if (found) begin
        res_next.granted       = 1'b1;
        res_next.granted_voice = 3'(pick);
      end
    end else begin
      res_next.release_mask = mask_ext[7:0];
      res_next.all_released = (active_count <= svalloc_pkg::COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      active_count <= '0;
      voice_busy   <= '0;
      found        <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        voice_note[v]    <= '0;
        release_stamp[v] <= '0;
      end
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur      <= req;
            idx      <= '0;
            pick     <= '0;
            found    <= 1'b0;
            best     <= '0;
            mask_ext <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur.req_type == svalloc_pkg::REQ_NOTE_ON) begin
            if (!voice_busy[idx]) begin
              if (idle_ext[idx]) begin
                pick  <= idx;
                found <= 1'b1;
              end else if (!found || (cur_stamp < best)) begin
                best  <= cur_stamp;
                pick  <= idx;
                found <= 1'b1;
              end
            end
            if ((!voice_busy[idx] && idle_ext[idx]) || (idx == IDX_LAST)) begin
              state <= S_COMMIT;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            if (voice_note[idx] == cur.note_number) begin
              voice_busy[idx]    <= 1'b0;
              release_stamp[idx] <= stamp_now;
              mask_ext[idx]      <= 1'b1;
            end
            if (idx == IDX_LAST) begin
              state <= S_COMMIT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_COMMIT: begin
          res <= res_next;
          if (cur.req_type == svalloc_pkg::REQ_NOTE_ON) begin
            if (found) begin
              voice_note[pick] <= cur.note_number;
              voice_busy[pick] <= 1'b1;
              if (active_count < svalloc_pkg::COUNT_MAX) begin
                active_count <= active_count + 1'b1;
              end
            end
          end else begin
            if (active_count <= svalloc_pkg::COUNT_W'(1)) begin
              active_count <= '0;
            end else begin
              active_count <= active_count - 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_scan, req_valid && !req_stall, state == S_SCAN, "accept did not start scan")
  `ASSERT_CLK(a_rsp_exclusive, rsp_valid |-> !(rsp.granted && |rsp.release_mask), "grant with release")
  `ASSERT_NEXT(a_grant_busy, commit_on && found, voice_busy[pick], "granted voice not busy")
  `ASSERT_CLK(a_scan_found, (commit_on && !found) |-> (voice_busy == '1), "free voice missed")

endmodule

`default_nettype wire
